>>> src/e2u_pkg.sv
// shared types, constants and the month table for the unix seconds to utc date block
// used by e2u_split, e2u_tod, e2u_civil and epoch_seconds_to_utc_date
package e2u_pkg;

	// configuration register reset value
	localparam logic [37:0] MAX_SECONDS_RESET = 38'd2147483647;

	// register stages of the civil date section
	localparam int CIVIL_STAGES = 14;

	// seconds per day is 128 * 675; floor(2^31 / 675) is the reciprocal of the odd part
	localparam logic [21:0] RECIP_675  = 22'd3181457;
	localparam logic [9:0]  DIV_675    = 10'd675;

	// hour split: 3600 = 16 * 225, floor(2^13 / 225)
	localparam logic [5:0]  RECIP_225  = 6'd36;
	localparam logic [7:0]  DIV_225    = 8'd225;

	// minute split: 60 = 4 * 15, floor(2^10 / 15)
	localparam logic [6:0]  RECIP_15   = 7'd68;
	localparam logic [3:0]  DIV_15     = 4'd15;

	// civil date from day count: shift to 0000-03-01, 400-year eras
	localparam logic [21:0] DAYS_OFFSET  = 22'd719468;
	localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
	localparam logic [4:0]  RECIP_ERA    = 5'd28;     // floor(2^22 / 146097)
	localparam logic [10:0] DAYS_4Y      = 11'd1460;
	localparam logic [7:0]  RECIP_4Y     = 8'd179;    // floor(2^18 / 1460)
	localparam logic [17:0] DAYS_100Y    = 18'd36524;
	localparam logic [17:0] DAYS_ERA_M1  = 18'd146096;
	localparam logic [8:0]  DAYS_1Y      = 9'd365;
	localparam logic [9:0]  RECIP_1Y     = 10'd718;   // floor(2^18 / 365)
	localparam logic [8:0]  YEARS_400    = 9'd400;

	// input and result items
	typedef struct packed {
		logic signed [63:0] seconds;
		logic               in_null;
	} item_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        out_null;
	} result_t;

	// day count and seconds of day after the clamp and split
	typedef struct packed {
		logic [21:0] days;
		logic [16:0] rem;
		logic        is_null;
	} split_t;

	// time of day, carried alongside the date math
	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic       is_null;
	} hms_t;

	typedef struct packed {
		logic [21:0] days;
		hms_t        hms;
	} tod_t;

	// first day of each month in a march-based year
	function automatic logic [8:0] mon_start(input logic [3:0] mp);
		logic [8:0] s;
		unique case (mp)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd61;
			4'd3:    s = 9'd92;
			4'd4:    s = 9'd122;
			4'd5:    s = 9'd153;
			4'd6:    s = 9'd184;
			4'd7:    s = 9'd214;
			4'd8:    s = 9'd245;
			4'd9:    s = 9'd275;
			4'd10:   s = 9'd306;
			4'd11:   s = 9'd337;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

endpackage

>>> src/epoch_seconds_to_utc_date.sv
// Unix seconds to UTC calendar date and time, top level.
// Instantiates e2u_split, e2u_tod and e2u_civil; depends on e2u_pkg.
//
// Usage:
//   Drive item (seconds, in_null) and pulse start. busy is always low, so an
//   item is taken at every edge where start is high, one per clock cycle.
//   Each item gives one result: done is high for one cycle with the date and
//   time on result. Results come out in input order. The pipeline is 24
//   register stages: 4 for the clamp and the split into days and seconds of
//   day, 6 for hour/minute/second, and 14 for the civil date, set by the chain
//   of reciprocal divides and corrections. Throughput is one item per cycle.
//   max_seconds is written through max_seconds_we / max_seconds_wdata; the user
//   writes it only while no item is in flight, which the block does not
//   enforce. It takes effect for items started after the write. Reset clears
//   all valid bits, so no result appears until items are started, and loads
//   max_seconds with 2147483647. There is no output stall: done is a strobe and
//   the receiver must take each result in its cycle.
module epoch_seconds_to_utc_date (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  e2u_pkg::item_t     item,
	input  logic               max_seconds_we,
	input  logic [37:0]        max_seconds_wdata,
	output logic               done,
	output e2u_pkg::result_t   result
);

	logic [37:0]       max_seconds_q;
	logic              split_vld, tod_vld;
	e2u_pkg::split_t   split;
	e2u_pkg::tod_t     tod;

	// clamp register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_seconds_q <= e2u_pkg::MAX_SECONDS_RESET;
		end else if (max_seconds_we) begin
			max_seconds_q <= max_seconds_wdata;
		end
	end

	// fully pipelined, never refuses a transfer
	assign busy = 1'b0;

	// clamp and day split
	e2u_split u_split (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (start),
		.item        (item),
		.max_seconds (max_seconds_q),
		.out_valid   (split_vld),
		.split       (split)
	);

	// time of day
	e2u_tod u_tod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (split_vld),
		.split     (split),
		.out_valid (tod_vld),
		.tod       (tod)
	);

	// calendar date and result register
	e2u_civil u_civil (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tod_vld),
		.tod       (tod),
		.out_valid (done),
		.result    (result)
	);

endmodule

>>> src/e2u_split.sv
// clamp of the input seconds and split into day count and seconds of day
// four register stages; depends on e2u_pkg
module e2u_split (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  e2u_pkg::item_t     item,
	input  logic [37:0]        max_seconds,
	output logic               out_valid,
	output e2u_pkg::split_t    split
);

	logic        pos_c, over_c;
	logic [37:0] t_c;
	logic [52:0] prod_c;
	logic [31:0] qd_c;
	logic [31:0] r0_full_c;
	logic        ge_c;
	logic [10:0] r_c;

	logic        vld_s1, vld_s2, vld_s3, vld_s4;
	logic [37:0] t_s1;
	logic        null_s1, null_s2, null_s3;
	logic [30:0] x_s2;
	logic [21:0] q0_s2, q0_s3;
	logic [6:0]  low_s2, low_s3;
	logic [10:0] r0_s3;
	e2u_pkg::split_t split_s4;

	// clamp to the epoch below and to the register above
	always_comb begin
		pos_c  = !item.seconds[63] && (item.seconds != 64'sd0);
		over_c = (|item.seconds[62:38]) || (item.seconds[37:0] >= max_seconds);
		if (!pos_c) begin
			t_c = '0;
		end else if (over_c) begin
			t_c = max_seconds;
		end else begin
			t_c = item.seconds[37:0];
		end
	end

	// quotient estimate of (t >> 7) / 675, low by at most one
	assign prod_c = {22'b0, t_s1[37:7]} * {31'b0, e2u_pkg::RECIP_675};

	// remainder of the estimate, below twice the divisor
	assign qd_c      = {10'b0, q0_s2} * {22'b0, e2u_pkg::DIV_675};
	assign r0_full_c = {1'b0, x_s2} - qd_c;

	// single correction step
	assign ge_c = r0_s3 >= {1'b0, e2u_pkg::DIV_675};
	assign r_c  = ge_c ? (r0_s3 - {1'b0, e2u_pkg::DIV_675}) : r0_s3;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		t_s1    <= t_c;
		null_s1 <= item.in_null;

		x_s2    <= t_s1[37:7];
		low_s2  <= t_s1[6:0];
		q0_s2   <= prod_c[52:31];
		null_s2 <= null_s1;

		q0_s3   <= q0_s2;
		low_s3  <= low_s2;
		r0_s3   <= r0_full_c[10:0];
		null_s3 <= null_s2;

		split_s4.days    <= q0_s3 + {21'b0, ge_c};
		split_s4.rem     <= {r_c[9:0], low_s3};
		split_s4.is_null <= null_s3;
	end

	assign out_valid = vld_s4;
	assign split     = split_s4;

endmodule

>>> src/e2u_tod.sv
// hour, minute and second from the seconds of the day
// six register stages of reciprocal divide and correction; depends on e2u_pkg
module e2u_tod (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  e2u_pkg::split_t   split,
	output logic              out_valid,
	output e2u_pkg::tod_t     tod
);

	logic [18:0] hprod_c;
	logic [12:0] hq_c, rh_full_c;
	logic        hge_c;
	logic [8:0]  rh_c;
	logic [16:0] mprod_c;
	logic [9:0]  mq_c, rm_full_c;
	logic        mge_c;
	logic [4:0]  rm_c;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [21:0] days_s1, days_s2, days_s3, days_s4, days_s5;
	logic        null_s1, null_s2, null_s3, null_s4, null_s5;
	logic [12:0] hx_s1;
	logic [4:0]  h0_s1, h0_s2, hour_s3, hour_s4, hour_s5;
	logic [3:0]  low4_s1, low4_s2;
	logic [8:0]  rh_s2;
	logic [11:0] ms_s3;
	logic [9:0]  mx_s4;
	logic [5:0]  m0_s4, m0_s5;
	logic [1:0]  low2_s4, low2_s5;
	logic [4:0]  rm_s5;
	e2u_pkg::tod_t tod_s6;

	// hour estimate: (rem >> 4) / 225
	assign hprod_c = {6'b0, split.rem[16:4]} * {13'b0, e2u_pkg::RECIP_225};

	// hour remainder, below 450
	assign hq_c      = {8'b0, h0_s1} * {5'b0, e2u_pkg::DIV_225};
	assign rh_full_c = hx_s1 - hq_c;

	// hour correction and seconds within the hour
	assign hge_c = rh_s2 >= {1'b0, e2u_pkg::DIV_225};
	assign rh_c  = hge_c ? (rh_s2 - {1'b0, e2u_pkg::DIV_225}) : rh_s2;

	// minute estimate: (ms >> 2) / 15
	assign mprod_c = {7'b0, ms_s3[11:2]} * {10'b0, e2u_pkg::RECIP_15};

	// minute remainder, below 30
	assign mq_c      = {4'b0, m0_s4} * {6'b0, e2u_pkg::DIV_15};
	assign rm_full_c = mx_s4 - mq_c;

	// minute correction
	assign mge_c = rm_s5 >= {1'b0, e2u_pkg::DIV_15};
	assign rm_c  = mge_c ? (rm_s5 - {1'b0, e2u_pkg::DIV_15}) : rm_s5;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		hx_s1   <= split.rem[16:4];
		low4_s1 <= split.rem[3:0];
		h0_s1   <= hprod_c[17:13];
		days_s1 <= split.days;
		null_s1 <= split.is_null;

		h0_s2   <= h0_s1;
		low4_s2 <= low4_s1;
		rh_s2   <= rh_full_c[8:0];
		days_s2 <= days_s1;
		null_s2 <= null_s1;

		hour_s3 <= h0_s2 + {4'b0, hge_c};
		ms_s3   <= {rh_c[7:0], low4_s2};
		days_s3 <= days_s2;
		null_s3 <= null_s2;

		mx_s4   <= ms_s3[11:2];
		low2_s4 <= ms_s3[1:0];
		m0_s4   <= mprod_c[15:10];
		hour_s4 <= hour_s3;
		days_s4 <= days_s3;
		null_s4 <= null_s3;

		m0_s5   <= m0_s4;
		low2_s5 <= low2_s4;
		rm_s5   <= rm_full_c[4:0];
		hour_s5 <= hour_s4;
		days_s5 <= days_s4;
		null_s5 <= null_s4;

		tod_s6.days        <= days_s5;
		tod_s6.hms.hour    <= hour_s5;
		tod_s6.hms.minute  <= m0_s5 + {5'b0, mge_c};
		tod_s6.hms.second  <= {rm_c[3:0], low2_s5};
		tod_s6.hms.is_null <= null_s5;
	end

	assign out_valid = vld_s6;
	assign tod       = tod_s6;

endmodule

>>> src/e2u_civil.sv
// civil year, month and day from a day count, plus the final result register
// fourteen register stages; depends on e2u_pkg
module e2u_civil (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  e2u_pkg::tod_t     tod,
	output logic              out_valid,
	output e2u_pkg::result_t  result
);

	logic [26:0] eprod_c;
	logic [22:0] eq_c, doe0_full_c;
	logic        ege_c;
	logic [25:0] aprod_c;
	logic [2:0]  b_c;
	logic [17:0] aq_c, ra_full_c;
	logic        age_c;
	logic [17:0] yn_c;
	logic [27:0] yprod_c;
	logic [17:0] yq_c, ry_full_c;
	logic [1:0]  c100_c;
	logic [17:0] p_c;
	logic [13:0] ybase_c;
	logic [17:0] doy_full_c;
	logic [3:0]  mp_c;
	logic [8:0]  day_full_c;
	logic [3:0]  month_c;
	logic        early_c;

	logic [e2u_pkg::CIVIL_STAGES:1] vld_s;
	e2u_pkg::hms_t hms_s1, hms_s2, hms_s3, hms_s4, hms_s5, hms_s6, hms_s7;
	e2u_pkg::hms_t hms_s8, hms_s9, hms_s10, hms_s11, hms_s12, hms_s13;
	logic [21:0] z_s1, z_s2;
	logic [4:0]  era0_s2, era0_s3;
	logic [18:0] doe0_s3;
	logic [4:0]  era_s4, era_s5, era_s6, era_s7, era_s8, era_s9, era_s10;
	logic [17:0] doe_s4, doe_s5, doe_s6, doe_s7, doe_s8, doe_s9, doe_s10, doe_s11;
	logic [7:0]  a0_s5, a0_s6;
	logic [2:0]  b_s5, b_s6;
	logic        c_s5, c_s6;
	logic [11:0] ra_s6;
	logic [17:0] yn_s7, yn_s8;
	logic [8:0]  yoe0_s8, yoe0_s9;
	logic [9:0]  ry_s9;
	logic [8:0]  yoe_s10;
	logic [17:0] p_s11;
	logic [13:0] ybase_s11, ybase_s12, ybase_s13;
	logic [8:0]  doy_s12, doy_s13;
	logic [3:0]  mp_s13;
	e2u_pkg::result_t res_s14;

	// era estimate: z / 146097
	assign eprod_c = {5'b0, z_s1} * {22'b0, e2u_pkg::RECIP_ERA};

	// day of era before correction
	assign eq_c        = {18'b0, era0_s2} * {5'b0, e2u_pkg::DAYS_PER_ERA};
	assign doe0_full_c = {1'b0, z_s2} - eq_c;

	// era correction
	assign ege_c = doe0_s3 >= {1'b0, e2u_pkg::DAYS_PER_ERA};

	// four-year count estimate, century count and last day of the era
	assign aprod_c = {8'b0, doe_s4} * {18'b0, e2u_pkg::RECIP_4Y};
	always_comb begin
		b_c = '0;
		if (doe_s4 >= e2u_pkg::DAYS_100Y) b_c = 3'd1;
		if (doe_s4 >= {e2u_pkg::DAYS_100Y[16:0], 1'b0}) b_c = 3'd2;
		if (doe_s4 >= 18'd109572) b_c = 3'd3;
		if (doe_s4 >= e2u_pkg::DAYS_ERA_M1) b_c = 3'd4;
	end

	// four-year remainder
	assign aq_c      = {10'b0, a0_s5} * {7'b0, e2u_pkg::DAYS_4Y};
	assign ra_full_c = doe_s5 - aq_c;

	// leap-adjusted day of era
	assign age_c = ra_s6 >= {1'b0, e2u_pkg::DAYS_4Y};
	assign yn_c  = doe_s6 - {10'b0, a0_s6} - {17'b0, age_c} + {15'b0, b_s6} - {17'b0, c_s6};

	// year of era estimate
	assign yprod_c = {10'b0, yn_s7} * {18'b0, e2u_pkg::RECIP_1Y};

	// year of era remainder
	assign yq_c      = {9'b0, yoe0_s8} * {9'b0, e2u_pkg::DAYS_1Y};
	assign ry_full_c = yn_s8 - yq_c;

	// days before the year of era, and base year
	always_comb begin
		c100_c = '0;
		if (yoe_s10 >= 9'd100) c100_c = 2'd1;
		if (yoe_s10 >= 9'd200) c100_c = 2'd2;
		if (yoe_s10 >= 9'd300) c100_c = 2'd3;
	end
	assign p_c = ({9'b0, yoe_s10} * {9'b0, e2u_pkg::DAYS_1Y})
		+ {11'b0, yoe_s10[8:2]} - {16'b0, c100_c};
	assign ybase_c = {5'b0, yoe_s10}
		+ ({9'b0, era_s10} * {5'b0, e2u_pkg::YEARS_400});

	// day of year
	assign doy_full_c = doe_s11 - p_s11;

	// month of the march-based year
	always_comb begin
		mp_c = '0;
		for (int k = 1; k < 12; k++) begin
			if (doy_s12 >= e2u_pkg::mon_start(4'(k))) mp_c = 4'(k);
		end
	end

	// day, month and year fix-up
	assign day_full_c = doy_s13 - e2u_pkg::mon_start(mp_s13) + 9'd1;
	assign early_c    = mp_s13 >= 4'd10;
	assign month_c    = early_c ? (mp_s13 - 4'd9) : (mp_s13 + 4'd3);

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[e2u_pkg::CIVIL_STAGES-1:1], in_valid};
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		z_s1   <= tod.days + e2u_pkg::DAYS_OFFSET;
		hms_s1 <= tod.hms;

		z_s2    <= z_s1;
		era0_s2 <= eprod_c[26:22];
		hms_s2  <= hms_s1;

		era0_s3 <= era0_s2;
		doe0_s3 <= doe0_full_c[18:0];
		hms_s3  <= hms_s2;

		era_s4 <= era0_s3 + {4'b0, ege_c};
		doe_s4 <= ege_c ? (doe0_s3[17:0] - e2u_pkg::DAYS_PER_ERA) : doe0_s3[17:0];
		hms_s4 <= hms_s3;

		era_s5 <= era_s4;
		doe_s5 <= doe_s4;
		a0_s5  <= aprod_c[25:18];
		b_s5   <= b_c;
		c_s5   <= doe_s4 == e2u_pkg::DAYS_ERA_M1;
		hms_s5 <= hms_s4;

		era_s6 <= era_s5;
		doe_s6 <= doe_s5;
		a0_s6  <= a0_s5;
		b_s6   <= b_s5;
		c_s6   <= c_s5;
		ra_s6  <= ra_full_c[11:0];
		hms_s6 <= hms_s5;

		era_s7 <= era_s6;
		doe_s7 <= doe_s6;
		yn_s7  <= yn_c;
		hms_s7 <= hms_s6;

		era_s8  <= era_s7;
		doe_s8  <= doe_s7;
		yn_s8   <= yn_s7;
		yoe0_s8 <= yprod_c[26:18];
		hms_s8  <= hms_s7;

		era_s9  <= era_s8;
		doe_s9  <= doe_s8;
		yoe0_s9 <= yoe0_s8;
		ry_s9   <= ry_full_c[9:0];
		hms_s9  <= hms_s8;

		era_s10 <= era_s9;
		doe_s10 <= doe_s9;
		yoe_s10 <= yoe0_s9 + {8'b0, (ry_s9 >= {1'b0, e2u_pkg::DAYS_1Y})};
		hms_s10 <= hms_s9;

		doe_s11   <= doe_s10;
		p_s11     <= p_c;
		ybase_s11 <= ybase_c;
		hms_s11   <= hms_s10;

		doy_s12   <= doy_full_c[8:0];
		ybase_s12 <= ybase_s11;
		hms_s12   <= hms_s11;

		doy_s13   <= doy_s12;
		mp_s13    <= mp_c;
		ybase_s13 <= ybase_s12;
		hms_s13   <= hms_s12;

		// null results carry zeros in every date and time field
		if (hms_s13.is_null) begin
			res_s14.year     <= '0;
			res_s14.month    <= '0;
			res_s14.day      <= '0;
			res_s14.hour     <= '0;
			res_s14.minute   <= '0;
			res_s14.second   <= '0;
			res_s14.out_null <= 1'b1;
		end else begin
			res_s14.year     <= ybase_s13 + {13'b0, early_c};
			res_s14.month    <= month_c;
			res_s14.day      <= day_full_c[4:0];
			res_s14.hour     <= hms_s13.hour;
			res_s14.minute   <= hms_s13.minute;
			res_s14.second   <= hms_s13.second;
			res_s14.out_null <= 1'b0;
		end
	end

	assign out_valid = vld_s[e2u_pkg::CIVIL_STAGES];
	assign result    = res_s14;

endmodule
